// ----- hdl/assert_macros.svh -----
// assertion macros shared by checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert a property on the rising clock edge, held off during reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assert a same-cycle implication on the rising clock edge, held off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

// ----- hdl/lfu_pkg.sv -----
// package for the lfu cache: request and result structs, constants, types
// no dependencies
package lfu_pkg;
    localparam int Capacity = 16;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_PROBE  = 2'd1,
        FUNC_INSERT = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] layer_key;
        logic [15:0] expert_key;
        logic [31:0] payload_in;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] payload_out;
        logic [31:0] hit_count;
        logic [4:0]  entry_count;
        logic        evicted;
        logic [11:0] evicted_layer;
        logic [15:0] evicted_expert;
    } res_t;

    // contents of one cell
    typedef struct packed {
        logic              valid;
        logic [11:0]       layer;
        logic [15:0]       expert;
        logic [31:0]       payload;
        logic [31:0]       hits;
        logic [IdxW-1:0]   order;
    } entry_t;

    // token handed from cell to cell along the chain
    typedef struct packed {
        logic              match;
        logic [IdxW-1:0]   match_idx;
        logic              have_min;
        logic [IdxW-1:0]   min_idx;
        logic [31:0]       best_hits;
        logic [IdxW-1:0]   min_order;
        logic              have_free;
        logic [IdxW-1:0]   free_idx;
    } scan_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_DONE
    } state_t;
endpackage

// ----- hdl/lfu_cache_fifo_tiebreak_top.sv -----
// top level of the lfu cache: a row of cells and the sequencer
// depends on lfu_pkg, lfu_cell, lfu_ctrl
//
// channel  | direction | handshake
// request  | in        | start, accepted when busy is low
// result   | out       | done strobe, one cycle, no back-pressure
// config   | in        | cfg_we with cfg_wdata (entry_limit)
//
// every request runs through the scan, apply and done states before the next acceptance
// the scan token moves one cell per cycle during the scan, then one apply, one strobe
// an evicting insert renumbers in the apply cycle, so all requests cost the same
// reset empties the table and sets entry_limit to 16
// busy is high from acceptance until the result strobe; the receiver cannot stall
module lfu_cache_fifo_tiebreak_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  lfu_pkg::req_t req,
    output logic          busy,
    input  logic          cfg_we,
    input  logic [4:0]    cfg_wdata,
    output logic          done,
    output lfu_pkg::res_t res
);
    lfu_pkg::req_t                      cur_req;
    lfu_pkg::scan_t                     tok [lfu_pkg::Capacity+1];
    lfu_pkg::entry_t                    entries [lfu_pkg::Capacity];
    logic [lfu_pkg::IdxW-1:0]           rd_idx, wr_idx, dec_above;
    logic                               clear_all, wr_en, dec_en;
    lfu_pkg::entry_t                    wr_data;

    // row of cells
    for (genvar g = 0; g < lfu_pkg::Capacity; g++)
    begin : g_cell
        lfu_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .my_idx    (lfu_pkg::IdxW'(g)),
            .layer     (cur_req.layer_key),
            .expert    (cur_req.expert_key),
            .tok_in    (tok[g]),
            .tok_out   (tok[g+1]),
            .clear_all (clear_all),
            .wr_en     (wr_en && wr_idx == lfu_pkg::IdxW'(g)),
            .wr_data   (wr_data),
            .dec_en    (dec_en),
            .dec_above (dec_above),
            .entry     (entries[g])
        );
    end

    // sequencer
    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cur_req   (cur_req),
        .tok_seed  (tok[0]),
        .tok_last  (tok[lfu_pkg::Capacity]),
        .rd_entry  (entries[rd_idx]),
        .rd_idx    (rd_idx),
        .clear_all (clear_all),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data),
        .dec_en    (dec_en),
        .dec_above (dec_above),
        .done      (done),
        .res       (res)
    );
endmodule

// ----- hdl/lfu_cell.sv -----
// one cache cell: holds an entry and folds it into the passing scan token
// depends on lfu_pkg
module lfu_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [lfu_pkg::IdxW-1:0] my_idx,
    input  logic [11:0]              layer,
    input  logic [15:0]              expert,
    input  lfu_pkg::scan_t           tok_in,
    output lfu_pkg::scan_t           tok_out,
    input  logic                     clear_all,
    input  logic                     wr_en,
    input  lfu_pkg::entry_t          wr_data,
    input  logic                     dec_en,
    input  logic [lfu_pkg::IdxW-1:0] dec_above,
    output lfu_pkg::entry_t          entry
);
    logic                     valid_reg;
    logic [11:0]              layer_reg;
    logic [15:0]              expert_reg;
    logic [31:0]              payload_reg;
    logic [31:0]              hits_reg;
    logic [lfu_pkg::IdxW-1:0] order_reg;
    lfu_pkg::scan_t           tok_reg, tok_next;
    logic                     better;

    assign entry = '{valid: valid_reg, layer: layer_reg, expert: expert_reg,
                     payload: payload_reg, hits: hits_reg, order: order_reg};
    assign tok_out = tok_reg;

    // candidate check: fewer hits, or same hits and older
    assign better = valid_reg && (!tok_in.have_min ||
                    hits_reg < tok_in.best_hits ||
                    (hits_reg == tok_in.best_hits &&
                     order_reg < tok_in.min_order));

    // fold this cell into the token
    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.match && valid_reg && layer_reg == layer &&
            expert_reg == expert)
        begin
            tok_next.match     = 1'b1;
            tok_next.match_idx = my_idx;
        end
        if (better)
        begin
            tok_next.have_min  = 1'b1;
            tok_next.min_idx   = my_idx;
            tok_next.best_hits = hits_reg;
            tok_next.min_order = order_reg;
        end
        if (!tok_in.have_free && !valid_reg)
        begin
            tok_next.have_free = 1'b1;
            tok_next.free_idx  = my_idx;
        end
    end

    // token moves on to the next cell every cycle
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    // valid bit with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (clear_all)
            valid_reg <= 1'b0;
        else if (wr_en)
            valid_reg <= wr_data.valid;
    end

    // payload fields
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            layer_reg   <= wr_data.layer;
            expert_reg  <= wr_data.expert;
            payload_reg <= wr_data.payload;
            hits_reg    <= wr_data.hits;
            order_reg   <= wr_data.order;
        end
        else if (dec_en && valid_reg && order_reg > dec_above)
            order_reg <= order_reg - 1'b1;
    end
endmodule

// ----- hdl/lfu_ctrl.sv -----
// sequencer: runs the scan token down the cell row and applies the request
// depends on lfu_pkg
module lfu_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  lfu_pkg::req_t            req,
    output logic                     busy,
    input  logic                     cfg_we,
    input  logic [4:0]               cfg_wdata,
    output lfu_pkg::req_t            cur_req,
    output lfu_pkg::scan_t           tok_seed,
    input  lfu_pkg::scan_t           tok_last,
    input  lfu_pkg::entry_t          rd_entry,
    output logic [lfu_pkg::IdxW-1:0] rd_idx,
    output logic                     clear_all,
    output logic                     wr_en,
    output logic [lfu_pkg::IdxW-1:0] wr_idx,
    output lfu_pkg::entry_t          wr_data,
    output logic                     dec_en,
    output logic [lfu_pkg::IdxW-1:0] dec_above,
    output logic                     done,
    output lfu_pkg::res_t            res
);
    lfu_pkg::state_t            state_reg, state_next;
    lfu_pkg::req_t              req_reg;
    lfu_pkg::scan_t             scan_reg;
    lfu_pkg::res_t              res_reg, res_next;
    logic [4:0]                 limit_reg;
    logic [lfu_pkg::CntW-1:0]   total_reg, total_next;
    logic [lfu_pkg::CntW-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [lfu_pkg::CntW-1:0]   eff_limit;

    assign busy     = (state_reg != lfu_pkg::ST_IDLE);
    assign cur_req  = req_reg;
    assign tok_seed = '0;
    assign done     = (state_reg == lfu_pkg::ST_DONE);
    assign res      = res_reg;

    // limit clamped to 1..capacity
    always_comb
    begin
        if (limit_reg == 5'd0)
            eff_limit = lfu_pkg::CntW'(1);
        else if ({1'b0, limit_reg} > 6'(lfu_pkg::Capacity))
            eff_limit = lfu_pkg::CntW'(lfu_pkg::Capacity);
        else
            eff_limit = lfu_pkg::CntW'(limit_reg);
    end

    assign rd_idx = scan_reg.match ? scan_reg.match_idx : scan_reg.min_idx;

    // next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        res_next      = res_reg;
        total_next    = total_reg;
        scan_cnt_next = scan_cnt_reg;
        clear_all     = 1'b0;
        wr_en         = 1'b0;
        wr_idx        = scan_reg.match_idx;
        wr_data       = rd_entry;
        dec_en        = 1'b0;
        dec_above     = rd_entry.order;
        unique case (state_reg)
            lfu_pkg::ST_IDLE:
                if (start)
                begin
                    state_next    = lfu_pkg::ST_SCAN;
                    scan_cnt_next = '0;
                end
            lfu_pkg::ST_SCAN:
            begin
                // token moves one cell per cycle until it reaches the end of the row
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == lfu_pkg::CntW'(lfu_pkg::Capacity))
                    state_next = lfu_pkg::ST_APPLY;
            end
            lfu_pkg::ST_APPLY:
            begin
                res_next = '0;
                state_next = lfu_pkg::ST_DONE;
                if (req_reg.func == lfu_pkg::FUNC_CLEAR)
                begin
                    clear_all  = 1'b1;
                    total_next = '0;
                end
                else
                begin
                    res_next.found = scan_reg.match;
                    if (req_reg.func == lfu_pkg::FUNC_LOOKUP && scan_reg.match)
                    begin
                        wr_en = 1'b1;
                        if (rd_entry.hits != 32'hFFFF_FFFF)
                            wr_data.hits = rd_entry.hits + 32'd1;
                        res_next.payload_out = rd_entry.payload;
                        res_next.hit_count   = wr_data.hits;
                    end
                    else if (req_reg.func == lfu_pkg::FUNC_INSERT && scan_reg.match)
                    begin
                        wr_en = 1'b1;
                        wr_data.payload = req_reg.payload_in;
                    end
                    else if (req_reg.func == lfu_pkg::FUNC_INSERT)
                    begin
                        wr_data.valid   = 1'b1;
                        wr_data.layer   = req_reg.layer_key;
                        wr_data.expert  = req_reg.expert_key;
                        wr_data.payload = req_reg.payload_in;
                        wr_data.hits    = 32'd1;
                        if (total_reg >= eff_limit && scan_reg.have_min)
                        begin
                            // evict into the victim slot, new entry is newest,
                            // younger entries close the order gap in the same cycle
                            res_next.evicted        = 1'b1;
                            res_next.evicted_layer  = rd_entry.layer;
                            res_next.evicted_expert = rd_entry.expert;
                            wr_en          = 1'b1;
                            wr_idx         = scan_reg.min_idx;
                            wr_data.order  = lfu_pkg::IdxW'(total_reg - 1'b1);
                            dec_en         = 1'b1;
                        end
                        else if (scan_reg.have_free)
                        begin
                            wr_en         = 1'b1;
                            wr_idx        = scan_reg.free_idx;
                            wr_data.order = lfu_pkg::IdxW'(total_reg);
                            total_next    = total_reg + 1'b1;
                        end
                    end
                end
                res_next.entry_count = 5'(total_next);
            end
            lfu_pkg::ST_DONE:
                state_next = lfu_pkg::ST_IDLE;
            default:
                state_next = lfu_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lfu_pkg::ST_IDLE;
            total_reg    <= '0;
            limit_reg    <= 5'd16;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            scan_cnt_reg <= scan_cnt_next;
            if (cfg_we)
                limit_reg <= cfg_wdata;
        end
    end

    // request, scan and result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == lfu_pkg::ST_IDLE && start)
            req_reg <= req;
        if (state_reg == lfu_pkg::ST_SCAN &&
            scan_cnt_reg == lfu_pkg::CntW'(lfu_pkg::Capacity))
            scan_reg <= tok_last;
        res_reg <= res_next;
    end
endmodule

// ----- hdl/lfu_checker.sv -----
// port-level checker for the lfu cache, bound to the top level
// depends on lfu_pkg and assert_macros.svh
`include "assert_macros.svh"
module lfu_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input lfu_pkg::res_t res
);
    // a request accepted raises busy
    `ASSERT_CLK(a_busy_rise, clk, rst_n, (start && !busy) |=> busy, "busy not raised")
    // result strobe only while busy
    `ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy, "done while idle")
    // busy falls after a result strobe
    `ASSERT_CLK(a_done_free, clk, rst_n, done |=> !busy, "busy held after done")
    // entry count never exceeds capacity
    `ASSERT_IMPL(a_count, clk, rst_n, done, res.entry_count <= 5'd16, "count too big")
endmodule

bind lfu_cache_fifo_tiebreak_top lfu_checker u_lfu_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .res   (res)
);
